// ===== sv/ctc_pkg.sv =====
// ----------------------------------------------------------------------------
// ctc_pkg: shared definitions of the calendar time converter
// Command codes, pipeline depth, reciprocal constants for the constant
// divisions, and the small calendar tables.
// ----------------------------------------------------------------------------
package ctc_pkg;

  // Number of register stages from the input handshake to the result.
  localparam int NumStages = 7;

  typedef logic [NumStages-1:0] stage_vec_t;

  // Direction of one transaction.
  typedef enum logic {
    CMD_TO_DATE = 1'b0,
    CMD_TO_SECS = 1'b1
  } cmd_e;

  // Calendar constants.
  localparam int EpochYear        = 1970;
  localparam int EpochWeekday     = 4;       // 1970-01-01 was a Thursday.
  localparam int LeapsBeforeEpoch = 477;     // Leap years through 1969.
  localparam int CentYearA        = 2000;
  localparam int CentYearB        = 2100;
  localparam int DayOffset        = 719499;
  localparam int YearDays         = 365;
  localparam int WeekDays         = 7;
  localparam int HourSecs         = 3600;
  localparam int MinSecs          = 60;
  localparam int HoursPerDay      = 24;

  // Seconds per day is 675 << 7, so the day count is (t >> 7) / 675.
  // Each quotient below is floor(x * Recip >> Shift), which is at most one
  // short of the true quotient over the operand range, and then corrected.
  localparam int          DayUnits   = 675;
  localparam logic [25:0] DayRecip   = 26'd50903316;
  localparam int          DayShift   = 35;
  localparam logic [15:0] YearRecip  = 16'd45964;
  localparam int          YearShift  = 24;
  localparam logic [16:0] WeekRecip  = 17'd74898;
  localparam int          WeekShift  = 19;
  localparam logic [10:0] HourRecip  = 11'd1165;
  localparam int          HourShift  = 22;
  localparam logic [10:0] MinRecip   = 11'd1092;
  localparam int          MinShift   = 16;
  localparam int          Quad25     = 25;       // floor(y/100) = floor(floor(y/4)/25)
  localparam logic [10:0] Quad25Recip = 11'd1310;
  localparam int          Quad25Shift = 15;

  // Day of year at which a month starts in a common year, by month minus one.
  function automatic logic [8:0] month_start(input logic [3:0] idx);
    logic [8:0] res;
    unique case (idx)
      4'd0:    res = 9'd0;
      4'd1:    res = 9'd31;
      4'd2:    res = 9'd59;
      4'd3:    res = 9'd90;
      4'd4:    res = 9'd120;
      4'd5:    res = 9'd151;
      4'd6:    res = 9'd181;
      4'd7:    res = 9'd212;
      4'd8:    res = 9'd243;
      4'd9:    res = 9'd273;
      4'd10:   res = 9'd304;
      4'd11:   res = 9'd334;
      default: res = 9'd0;
    endcase
    return res;
  endfunction

  // Term (367 * m) / 12 of the March-based day formula.
  function automatic logic [8:0] month_term(input logic [3:0] mon);
    logic [8:0] res;
    unique case (mon)
      4'd0:  res = 9'd0;
      4'd1:  res = 9'd30;
      4'd2:  res = 9'd61;
      4'd3:  res = 9'd91;
      4'd4:  res = 9'd122;
      4'd5:  res = 9'd152;
      4'd6:  res = 9'd183;
      4'd7:  res = 9'd214;
      4'd8:  res = 9'd244;
      4'd9:  res = 9'd275;
      4'd10: res = 9'd305;
      4'd11: res = 9'd336;
      4'd12: res = 9'd367;
      4'd13: res = 9'd397;
      4'd14: res = 9'd428;
      4'd15: res = 9'd458;
      default: res = 9'd0;
    endcase
    return res;
  endfunction

endpackage

// ===== sv/ctc_to_date.sv =====
// ----------------------------------------------------------------------------
// ctc_to_date: seconds to calendar date datapath
// Seven register stages that split a 32-bit second count into year, month,
// day, time of day and weekday, using reciprocal multiplies for divisions.
// ----------------------------------------------------------------------------
module ctc_to_date (
  input  logic               clk_i,
  input  ctc_pkg::stage_vec_t ld_i,
  input  logic [31:0]        epoch_seconds_i,
  output logic [11:0]        year_o,
  output logic [3:0]         month_o,
  output logic [4:0]         day_o,
  output logic [4:0]         hour_o,
  output logic [5:0]         minute_o,
  output logic [5:0]         second_o,
  output logic [2:0]         weekday_o
);

  // Stage 1: estimate the day count from the upper 25 bits of the time.
  logic [24:0] s0_x;
  logic [50:0] s0_prod;
  logic [31:0] s1_time_q;
  logic [15:0] s1_quo_q;

  assign s0_x    = epoch_seconds_i[31:7];
  assign s0_prod = 51'(s0_x) * 51'(ctc_pkg::DayRecip);

  always_ff @(posedge clk_i) begin
    if (ld_i[0]) begin
      s1_time_q <= epoch_seconds_i;
      s1_quo_q  <= s0_prod[ctc_pkg::DayShift+15:ctc_pkg::DayShift];
    end
  end

  // Stage 2: correct the day count and form the seconds within the day.
  logic [24:0] s1_x;
  logic [24:0] s1_qm;
  logic [24:0] s1_r;
  logic [24:0] s1_rsub;
  logic        s1_fix;
  logic [15:0] s2_days_q;
  logic [16:0] s2_rem_q;

  assign s1_x    = s1_time_q[31:7];
  assign s1_qm   = 25'(s1_quo_q) * 25'(ctc_pkg::DayUnits);
  assign s1_r    = s1_x - s1_qm;
  assign s1_rsub = s1_r - 25'(ctc_pkg::DayUnits);
  assign s1_fix  = (s1_r >= 25'(ctc_pkg::DayUnits));

  always_ff @(posedge clk_i) begin
    if (ld_i[1]) begin
      s2_days_q <= s1_quo_q + 16'(s1_fix);
      s2_rem_q  <= {(s1_fix ? s1_rsub[9:0] : s1_r[9:0]), s1_time_q[6:0]};
    end
  end

  // Stage 3: estimate years, weeks and hours.
  logic [31:0] s2_yprod;
  logic [15:0] s2_dw;
  logic [32:0] s2_wprod;
  logic [27:0] s2_hprod;
  logic [15:0] s3_days_q;
  logic [7:0]  s3_yq_q;
  logic [12:0] s3_wq_q;
  logic [16:0] s3_rem_q;
  logic [4:0]  s3_hq_q;

  assign s2_yprod = 32'(s2_days_q) * 32'(ctc_pkg::YearRecip);
  assign s2_dw    = s2_days_q + 16'(ctc_pkg::EpochWeekday);
  assign s2_wprod = 33'(s2_dw) * 33'(ctc_pkg::WeekRecip);
  assign s2_hprod = 28'(s2_rem_q) * 28'(ctc_pkg::HourRecip);

  always_ff @(posedge clk_i) begin
    if (ld_i[2]) begin
      s3_days_q <= s2_days_q;
      s3_yq_q   <= s2_yprod[ctc_pkg::YearShift+7:ctc_pkg::YearShift];
      s3_wq_q   <= s2_wprod[ctc_pkg::WeekShift+12:ctc_pkg::WeekShift];
      s3_rem_q  <= s2_rem_q;
      s3_hq_q   <= s2_hprod[ctc_pkg::HourShift+4:ctc_pkg::HourShift];
    end
  end

  // Stage 4: correct the estimates; keep day within year estimate,
  // weekday, hour and seconds within the hour.
  logic [15:0] s3_dr;
  logic [15:0] s3_drsub;
  logic        s3_fixy;
  logic [15:0] s3_dw;
  logic [15:0] s3_wr;
  logic [15:0] s3_wrsub;
  logic [16:0] s3_hr;
  logic [16:0] s3_hrsub;
  logic        s3_fixh;
  logic [7:0]  s4_yq_q;
  logic [8:0]  s4_dofy_q;
  logic [2:0]  s4_wday_q;
  logic [4:0]  s4_hour_q;
  logic [11:0] s4_rem_q;

  assign s3_dr    = s3_days_q - 16'(s3_yq_q) * 16'(ctc_pkg::YearDays);
  assign s3_drsub = s3_dr - 16'(ctc_pkg::YearDays);
  assign s3_fixy  = (s3_dr >= 16'(ctc_pkg::YearDays));
  assign s3_dw    = s3_days_q + 16'(ctc_pkg::EpochWeekday);
  assign s3_wr    = s3_dw - 16'(s3_wq_q) * 16'(ctc_pkg::WeekDays);
  assign s3_wrsub = s3_wr - 16'(ctc_pkg::WeekDays);
  assign s3_hr    = s3_rem_q - 17'(s3_hq_q) * 17'(ctc_pkg::HourSecs);
  assign s3_hrsub = s3_hr - 17'(ctc_pkg::HourSecs);
  assign s3_fixh  = (s3_hr >= 17'(ctc_pkg::HourSecs));

  always_ff @(posedge clk_i) begin
    if (ld_i[3]) begin
      s4_yq_q   <= s3_yq_q + 8'(s3_fixy);
      s4_dofy_q <= s3_fixy ? s3_drsub[8:0] : s3_dr[8:0];
      s4_wday_q <= (s3_wr >= 16'(ctc_pkg::WeekDays)) ? s3_wrsub[2:0] : s3_wr[2:0];
      s4_hour_q <= s3_hq_q + 5'(s3_fixh);
      s4_rem_q  <= s3_fixh ? s3_hrsub[11:0] : s3_hr[11:0];
    end
  end

  // Stage 5: subtract the leap days since the epoch, estimate the minute.
  logic [11:0] s4_year;
  logic [11:0] s4_prev;
  logic [4:0]  s4_c100;
  logic [2:0]  s4_c400;
  logic [9:0]  s4_leaps;
  logic [22:0] s4_mprod;
  logic [11:0] s5_year_q;
  logic [9:0]  s5_d2_q;
  logic [5:0]  s5_mq_q;
  logic [11:0] s5_rem_q;
  logic [2:0]  s5_wday_q;
  logic [4:0]  s5_hour_q;

  assign s4_year = 12'(ctc_pkg::EpochYear) + 12'(s4_yq_q);
  assign s4_prev = s4_year - 12'd1;

  // Centuries and 400-year periods over the years this path can reach.
  always_comb begin
    priority if (s4_prev >= 12'(ctc_pkg::CentYearB)) begin
      s4_c100 = 5'd21;
      s4_c400 = 3'd5;
    end else if (s4_prev >= 12'(ctc_pkg::CentYearA)) begin
      s4_c100 = 5'd20;
      s4_c400 = 3'd5;
    end else begin
      s4_c100 = 5'd19;
      s4_c400 = 3'd4;
    end
  end

  assign s4_leaps = 10'(s4_prev[11:2]) - 10'(s4_c100) + 10'(s4_c400)
                  - 10'(ctc_pkg::LeapsBeforeEpoch);
  assign s4_mprod = 23'(s4_rem_q) * 23'(ctc_pkg::MinRecip);

  always_ff @(posedge clk_i) begin
    if (ld_i[4]) begin
      s5_year_q <= s4_year;
      s5_d2_q   <= {1'b0, s4_dofy_q} - {4'b0, s4_leaps[5:0]};
      s5_mq_q   <= s4_mprod[ctc_pkg::MinShift+5:ctc_pkg::MinShift];
      s5_rem_q  <= s4_rem_q;
      s5_wday_q <= s4_wday_q;
      s5_hour_q <= s4_hour_q;
    end
  end

  // Stage 6: back off one year when the day count went negative,
  // and finish minute and second.
  logic        s5_neg;
  logic [11:0] s5_year2;
  logic        s5_leap;
  logic [9:0]  s5_d3;
  logic [11:0] s5_mr;
  logic [11:0] s5_mrsub;
  logic        s5_fixm;
  logic [11:0] s6_year_q;
  logic [8:0]  s6_dofy_q;
  logic        s6_leap_q;
  logic [5:0]  s6_min_q;
  logic [5:0]  s6_sec_q;
  logic [4:0]  s6_hour_q;
  logic [2:0]  s6_wday_q;

  assign s5_neg   = s5_d2_q[9];
  assign s5_year2 = s5_neg ? (s5_year_q - 12'd1) : s5_year_q;
  assign s5_leap  = (s5_year2[1:0] == 2'b00) && (s5_year2 != 12'(ctc_pkg::CentYearB));
  assign s5_d3    = s5_neg ? (s5_d2_q + 10'(ctc_pkg::YearDays) + 10'(s5_leap)) : s5_d2_q;
  assign s5_mr    = s5_rem_q - 12'(s5_mq_q) * 12'(ctc_pkg::MinSecs);
  assign s5_mrsub = s5_mr - 12'(ctc_pkg::MinSecs);
  assign s5_fixm  = (s5_mr >= 12'(ctc_pkg::MinSecs));

  always_ff @(posedge clk_i) begin
    if (ld_i[5]) begin
      s6_year_q <= s5_year2;
      s6_dofy_q <= s5_d3[8:0];
      s6_leap_q <= s5_leap;
      s6_min_q  <= s5_mq_q + 6'(s5_fixm);
      s6_sec_q  <= s5_fixm ? s5_mrsub[5:0] : s5_mr[5:0];
      s6_hour_q <= s5_hour_q;
      s6_wday_q <= s5_wday_q;
    end
  end

  // Stage 7: find the month by comparing against the month boundaries.
  logic [3:0] s6_cnt;
  logic [8:0] s6_start;
  logic [8:0] s6_day;

  always_comb begin
    s6_cnt = 4'd0;
    for (int k = 1; k < 12; k++) begin
      if (s6_dofy_q >= ctc_pkg::month_start(4'(k)) + 9'(s6_leap_q && (k >= 2))) begin
        s6_cnt = s6_cnt + 4'd1;
      end
    end
  end

  assign s6_start = ctc_pkg::month_start(s6_cnt) + 9'(s6_leap_q && (s6_cnt >= 4'd2));
  assign s6_day   = s6_dofy_q - s6_start + 9'd1;

  always_ff @(posedge clk_i) begin
    if (ld_i[6]) begin
      year_o    <= s6_year_q;
      month_o   <= s6_cnt + 4'd1;
      day_o     <= s6_day[4:0];
      hour_o    <= s6_hour_q;
      minute_o  <= s6_min_q;
      second_o  <= s6_sec_q;
      weekday_o <= s6_wday_q;
    end
  end

endmodule

// ===== sv/ctc_to_secs.sv =====
// ----------------------------------------------------------------------------
// ctc_to_secs: calendar date to seconds datapath
// Seven register stages that evaluate the March-based day formula and scale
// the day count to seconds, all modulo 2^32.
// ----------------------------------------------------------------------------
module ctc_to_secs (
  input  logic               clk_i,
  input  ctc_pkg::stage_vec_t ld_i,
  input  logic [11:0]        in_year_i,
  input  logic [3:0]         in_month_i,
  input  logic [4:0]         in_day_i,
  input  logic [4:0]         in_hour_i,
  input  logic [5:0]         in_minute_i,
  input  logic [5:0]         in_second_i,
  output logic [31:0]        seconds_o
);

  // Stage 1: move the year start to March. January and February belong
  // to the previous year, which can go to minus one for year zero.
  logic        s0_wrap;
  logic [12:0] s0_ya;
  logic [3:0]  s0_ma;
  logic [12:0] s1_ya_q;
  logic [8:0]  s1_mterm_q;
  logic [9:0]  s1_q4_q;
  logic [4:0]  s1_day_q;
  logic [4:0]  s1_hour_q;
  logic [5:0]  s1_min_q;
  logic [5:0]  s1_sec_q;

  assign s0_wrap = (in_month_i <= 4'd2);
  assign s0_ya   = {1'b0, in_year_i} - 13'(s0_wrap);
  assign s0_ma   = s0_wrap ? (in_month_i + 4'd10) : (in_month_i - 4'd2);

  always_ff @(posedge clk_i) begin
    if (ld_i[0]) begin
      s1_ya_q    <= s0_ya;
      s1_mterm_q <= ctc_pkg::month_term(s0_ma);
      // Truncation toward zero leaves no leap years for year minus one.
      s1_q4_q    <= s0_ya[12] ? 10'd0 : s0_ya[11:2];
      s1_day_q   <= in_day_i;
      s1_hour_q  <= in_hour_i;
      s1_min_q   <= in_minute_i;
      s1_sec_q   <= in_second_i;
    end
  end

  // Stage 2: estimate the century count from the four-year count.
  logic [20:0] s1_cprod;
  logic [12:0] s2_ya_q;
  logic [8:0]  s2_mterm_q;
  logic [9:0]  s2_q4_q;
  logic [5:0]  s2_c100_q;
  logic [4:0]  s2_day_q;
  logic [4:0]  s2_hour_q;
  logic [5:0]  s2_min_q;
  logic [5:0]  s2_sec_q;

  assign s1_cprod = 21'(s1_q4_q) * 21'(ctc_pkg::Quad25Recip);

  always_ff @(posedge clk_i) begin
    if (ld_i[1]) begin
      s2_ya_q    <= s1_ya_q;
      s2_mterm_q <= s1_mterm_q;
      s2_q4_q    <= s1_q4_q;
      s2_c100_q  <= s1_cprod[ctc_pkg::Quad25Shift+5:ctc_pkg::Quad25Shift];
      s2_day_q   <= s1_day_q;
      s2_hour_q  <= s1_hour_q;
      s2_min_q   <= s1_min_q;
      s2_sec_q   <= s1_sec_q;
    end
  end

  // Stage 3: correct the century count and form the leap-year count.
  logic [9:0]  s2_cr;
  logic [5:0]  s2_c100;
  logic [12:0] s3_ya_q;
  logic [8:0]  s3_mterm_q;
  logic [9:0]  s3_leaps_q;
  logic [4:0]  s3_day_q;
  logic [4:0]  s3_hour_q;
  logic [5:0]  s3_min_q;
  logic [5:0]  s3_sec_q;

  assign s2_cr   = s2_q4_q - 10'(s2_c100_q) * 10'(ctc_pkg::Quad25);
  assign s2_c100 = s2_c100_q + 6'(s2_cr >= 10'(ctc_pkg::Quad25));

  always_ff @(posedge clk_i) begin
    if (ld_i[2]) begin
      s3_ya_q    <= s2_ya_q;
      s3_mterm_q <= s2_mterm_q;
      s3_leaps_q <= s2_q4_q - 10'(s2_c100) + 10'(s2_c100[5:2]);
      s3_day_q   <= s2_day_q;
      s3_hour_q  <= s2_hour_q;
      s3_min_q   <= s2_min_q;
      s3_sec_q   <= s2_sec_q;
    end
  end

  // Stage 4: day count since the epoch, modulo 2^32.
  logic [31:0] s3_yext;
  logic [31:0] s3_ydays;
  logic [31:0] s4_days_q;
  logic [4:0]  s4_hour_q;
  logic [5:0]  s4_min_q;
  logic [5:0]  s4_sec_q;

  assign s3_yext  = {{19{s3_ya_q[12]}}, s3_ya_q};
  assign s3_ydays = s3_yext * 32'(ctc_pkg::YearDays);

  always_ff @(posedge clk_i) begin
    if (ld_i[3]) begin
      s4_days_q <= 32'(s3_leaps_q) + 32'(s3_mterm_q) + 32'(s3_day_q) + s3_ydays
                 - 32'(ctc_pkg::DayOffset);
      s4_hour_q <= s3_hour_q;
      s4_min_q  <= s3_min_q;
      s4_sec_q  <= s3_sec_q;
    end
  end

  // Stage 5: hours.
  logic [31:0] s5_acc_q;
  logic [5:0]  s5_min_q;
  logic [5:0]  s5_sec_q;

  always_ff @(posedge clk_i) begin
    if (ld_i[4]) begin
      s5_acc_q <= s4_days_q * 32'(ctc_pkg::HoursPerDay) + 32'(s4_hour_q);
      s5_min_q <= s4_min_q;
      s5_sec_q <= s4_sec_q;
    end
  end

  // Stage 6: minutes.
  logic [31:0] s6_acc_q;
  logic [5:0]  s6_sec_q;

  always_ff @(posedge clk_i) begin
    if (ld_i[5]) begin
      s6_acc_q <= s5_acc_q * 32'(ctc_pkg::MinSecs) + 32'(s5_min_q);
      s6_sec_q <= s5_sec_q;
    end
  end

  // Stage 7: seconds.
  always_ff @(posedge clk_i) begin
    if (ld_i[6]) begin
      seconds_o <= s6_acc_q * 32'(ctc_pkg::MinSecs) + 32'(s6_sec_q);
    end
  end

endmodule

// ===== sv/calendar_time_converter.sv =====
// ----------------------------------------------------------------------------
// calendar_time_converter: seconds since 1970 to and from a Gregorian date
// The result comes from a seven-stage pipeline; one transaction can be
// accepted every cycle unless a stalled output backs up to the input stage.
// A stalled output holds its stage, and bubbles in the pipeline still fill.
// Reset clears only the stage valid bits; there is no clearing pass.
// ----------------------------------------------------------------------------
module calendar_time_converter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        command_i,
  input  logic [31:0] epoch_seconds_i,
  input  logic [11:0] in_year_i,
  input  logic [3:0]  in_month_i,
  input  logic [4:0]  in_day_i,
  input  logic [4:0]  in_hour_i,
  input  logic [5:0]  in_minute_i,
  input  logic [5:0]  in_second_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] out_seconds_o,
  output logic [11:0] out_year_o,
  output logic [3:0]  out_month_o,
  output logic [4:0]  out_day_o,
  output logic [4:0]  out_hour_o,
  output logic [5:0]  out_minute_o,
  output logic [5:0]  out_second_o,
  output logic [2:0]  out_weekday_o
);

  localparam int LastStage = ctc_pkg::NumStages - 1;

  ctc_pkg::stage_vec_t valid_q;
  ctc_pkg::stage_vec_t cmd_q;
  ctc_pkg::stage_vec_t ready;
  ctc_pkg::stage_vec_t up_valid;
  ctc_pkg::stage_vec_t up_cmd;
  ctc_pkg::stage_vec_t ld;

  // A stage can take new data when it is empty or its contents move on.
  always_comb begin
    ready[LastStage] = !valid_q[LastStage] || !out_stall_i;
    for (int k = LastStage - 1; k >= 0; k--) begin
      ready[k] = !valid_q[k] || ready[k+1];
    end
  end

  assign up_valid = {valid_q[LastStage-1:0], in_valid_i};
  assign up_cmd   = {cmd_q[LastStage-1:0], command_i};
  assign ld       = ready & up_valid;

  // Stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int k = 0; k < ctc_pkg::NumStages; k++) begin
        if (ready[k]) begin
          valid_q[k] <= up_valid[k];
        end
      end
    end
  end

  // The command of each transaction travels with its stage.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < ctc_pkg::NumStages; k++) begin
      if (ld[k]) begin
        cmd_q[k] <= up_cmd[k];
      end
    end
  end

  // Both directions run side by side; the command picks the result.
  logic [31:0] secs;
  logic [11:0] year;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;
  logic [2:0]  weekday;

  ctc_to_date u_to_date (
    .clk_i           (clk_i),
    .ld_i            (ld),
    .epoch_seconds_i (epoch_seconds_i),
    .year_o          (year),
    .month_o         (month),
    .day_o           (day),
    .hour_o          (hour),
    .minute_o        (minute),
    .second_o        (second),
    .weekday_o       (weekday)
  );

  ctc_to_secs u_to_secs (
    .clk_i       (clk_i),
    .ld_i        (ld),
    .in_year_i   (in_year_i),
    .in_month_i  (in_month_i),
    .in_day_i    (in_day_i),
    .in_hour_i   (in_hour_i),
    .in_minute_i (in_minute_i),
    .in_second_i (in_second_i),
    .seconds_o   (secs)
  );

  // Fields of the direction not chosen read as zero.
  logic sel_secs;

  assign sel_secs      = (cmd_q[LastStage] == ctc_pkg::CMD_TO_SECS);
  assign out_seconds_o = sel_secs ? secs : '0;
  assign out_year_o    = sel_secs ? '0 : year;
  assign out_month_o   = sel_secs ? '0 : month;
  assign out_day_o     = sel_secs ? '0 : day;
  assign out_hour_o    = sel_secs ? '0 : hour;
  assign out_minute_o  = sel_secs ? '0 : minute;
  assign out_second_o  = sel_secs ? '0 : second;
  assign out_weekday_o = sel_secs ? '0 : weekday;

  assign out_valid_o = valid_q[LastStage];
  assign in_stall_o  = !ready[0];

  // A full pipeline behind a stalled output must push back on the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((&valid_q) && out_stall_i) |-> in_stall_o)
    else $error("input not stalled while pipeline full and output stalled");

  // An accepted transaction occupies the first stage on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> valid_q[0])
    else $error("accepted transaction lost at first stage");

  // A date result always carries a real month, day and weekday.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !sel_secs) |->
      (out_month_o >= 4'd1 && out_month_o <= 4'd12 && out_day_o != 5'd0
       && out_weekday_o <= 3'd6))
    else $error("date result out of range");

endmodule
